@@ sv/wftt_pkg.sv @@
// Shared types, codes and helper functions for the word frequency table.
package wftt_pkg;

  localparam int unsigned TableDepthDef = 1024;
  localparam int unsigned WordCharsDef  = 29;
  localparam int unsigned TopCountDef   = 10;

  // Function codes on the input channel.
  localparam logic [1:0] FUNC_TEXT   = 2'd0;
  localparam logic [1:0] FUNC_REPORT = 2'd1;
  localparam logic [1:0] FUNC_READ   = 2'd2;
  localparam logic [1:0] FUNC_NONE   = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_RANKED  = 2'd0;
  localparam logic [1:0] KIND_CHAR    = 2'd1;
  localparam logic [1:0] KIND_DROPPED = 2'd2;
  localparam logic [1:0] KIND_EMPTY   = 2'd3;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] text_byte;
    logic [9:0] slot;
    logic [4:0] char_pos;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  rank;
    logic [9:0]  slot_out;
    logic [31:0] count;
    logic [4:0]  word_len;
    logic [7:0]  char_out;
    logic        last;
  } out_t;

  // Space, tab, newline, vertical tab, form feed, carriage return.
  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    return ((b >= CHAR_UPPER_A) && (b <= CHAR_UPPER_Z)) ? (b + CASE_OFFSET) : b;
  endfunction

endpackage

@@ sv/word_frequency_table_top_ten.sv @@
// Word frequency table with top-ten report, built around two entry memories.
// Operation: a text byte is taken while idle; a word end walks the used entries up to its
//   match; a report takes up to TOP_COUNT walks of the used entries, one per rank; a
//   character read takes one memory read. One item at a time.
// Throughput is set by the single read port of the entry memories, one entry per cycle.
// Reset (rst_ni low, asynchronous) empties the table through its fill count and
//   clears the pending word; no clearing pass is needed.
module word_frequency_table_top_ten #(
  parameter int unsigned TABLE_DEPTH = wftt_pkg::TableDepthDef,
  parameter int unsigned WORD_CHARS  = wftt_pkg::WordCharsDef,
  parameter int unsigned TOP_COUNT   = wftt_pkg::TopCountDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  wftt_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output wftt_pkg::out_t out_data_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned LW = $clog2(WORD_CHARS + 1);
  localparam int unsigned PW = (WORD_CHARS > 1) ? $clog2(WORD_CHARS) : 1;
  localparam int unsigned RW = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;

  typedef struct packed {
    logic          taken;
    logic [LW-1:0] len;
    logic [31:0]   cnt;
  } meta_t;

  typedef logic [WORD_CHARS-1:0][7:0] row_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RANK,
    S_DROP,
    S_READ
  } state_e;

  // Entry memories: per-entry metadata and the stored characters, one row per entry.
  meta_t meta_mem  [TABLE_DEPTH];
  row_t  chars_mem [TABLE_DEPTH];
  meta_t meta_rd_q;
  row_t  chars_rd_q;

  state_e         state_q;
  logic [AW:0]    used_q;
  logic [AW:0]    idx_q;
  logic [AW:0]    cidx_q;
  logic           vld_q;
  row_t           pend_q;
  logic [LW-1:0]  plen_q;
  logic           mode_rep_q;
  logic           dropped_q;
  logic [LW-1:0]  drop_len_q;
  logic [RW-1:0]  rank_q;
  logic           found_q;
  logic           more_q;
  logic [31:0]    best_q;
  logic [AW:0]    bslot_q;
  logic [LW-1:0]  blen_q;
  logic [9:0]     rslot_q;
  logic [4:0]     rpos_q;
  logic           out_valid_q;
  wftt_pkg::out_t out_q;

  logic           accept;
  logic           out_free;
  logic           rd_issue;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic           scan_done;
  logic           word_match;
  logic           table_full;
  logic           meta_we;
  logic [AW-1:0]  meta_wa;
  meta_t          meta_wd;
  logic           chars_we;
  logic           more_ranks;
  logic           drop_follows;
  logic           read_hit;
  logic [31:0]    cnt_inc;
  logic           out_set;
  wftt_pkg::out_t out_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Stop issuing reads once a match is seen so no stale entry follows into the next walk.
  assign rd_issue   = ((state_q == S_SCAN) || (state_q == S_RANK)) && (idx_q < used_q) &&
                      !((state_q == S_SCAN) && vld_q && word_match);
  assign scan_done  = !vld_q && !(idx_q < used_q);
  assign table_full = (used_q >= (AW+1)'(TABLE_DEPTH));
  assign cnt_inc    = (meta_rd_q.cnt == 32'hFFFF_FFFF) ? meta_rd_q.cnt : meta_rd_q.cnt + 32'd1;

  // A later rank or a dropped-word report follows only below the last rank.
  assign more_ranks   = (32'(rank_q) < TOP_COUNT - 1) && more_q;
  assign drop_follows = (32'(rank_q) < TOP_COUNT - 1) && dropped_q;

  assign read_hit = (32'(rslot_q) < 32'(used_q));

  // Compare the stored row against the pending word over its length only.
  always_comb begin
    word_match = (meta_rd_q.len == plen_q);
    for (int k = 0; k < WORD_CHARS; k++) begin
      if ((k < 32'(plen_q)) && (chars_rd_q[k] != pend_q[k])) begin
        word_match = 1'b0;
      end
    end
  end

  always_comb begin
    rd_en   = rd_issue || (accept && (in_data_i.func == wftt_pkg::FUNC_READ));
    rd_addr = (state_q == S_IDLE) ? AW'(in_data_i.slot) : idx_q[AW-1:0];
  end

  // Memory writes: bump a matched count, insert a new word, or mark a ranked entry.
  always_comb begin
    meta_we  = 1'b0;
    chars_we = 1'b0;
    meta_wa  = cidx_q[AW-1:0];
    meta_wd  = '{taken: meta_rd_q.taken, len: meta_rd_q.len, cnt: cnt_inc};
    case (state_q)
      S_SCAN: begin
        if (vld_q && word_match) begin
          meta_we = 1'b1;
        end else if (scan_done && !table_full) begin
          meta_we  = 1'b1;
          chars_we = 1'b1;
          meta_wa  = used_q[AW-1:0];
          meta_wd  = '{taken: 1'b0, len: plen_q, cnt: 32'd1};
        end
      end
      S_RANK: begin
        if (scan_done && out_free && found_q) begin
          meta_we = 1'b1;
          meta_wa = bslot_q[AW-1:0];
          meta_wd = '{taken: 1'b1, len: blen_q, cnt: best_q};
        end
      end
      default: begin
      end
    endcase
  end

  // Result transfer to load into the output register, and when to load it.
  always_comb begin
    out_set = 1'b0;
    out_d   = '0;
    case (state_q)
      S_RANK: begin
        out_set = scan_done && out_free;
        if (found_q) begin
          out_d.kind     = wftt_pkg::KIND_RANKED;
          out_d.rank     = 4'(rank_q);
          out_d.slot_out = 10'(bslot_q);
          out_d.count    = best_q;
          out_d.word_len = 5'(blen_q);
          out_d.last     = !more_ranks && !drop_follows;
        end else begin
          out_d.kind = wftt_pkg::KIND_EMPTY;
          out_d.last = !(dropped_q && (TOP_COUNT > 1));
        end
      end
      S_DROP: begin
        out_set        = out_free;
        out_d.kind     = wftt_pkg::KIND_DROPPED;
        out_d.word_len = 5'(drop_len_q);
        out_d.last     = 1'b1;
      end
      S_READ: begin
        out_set        = out_free;
        out_d.kind     = wftt_pkg::KIND_CHAR;
        out_d.slot_out = rslot_q;
        out_d.last     = 1'b1;
        if (read_hit) begin
          out_d.count    = meta_rd_q.cnt;
          out_d.word_len = 5'(meta_rd_q.len);
          if (32'(rpos_q) < 32'(meta_rd_q.len)) begin
            out_d.char_out = chars_rd_q[PW'(rpos_q)];
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (meta_we) begin
      meta_mem[meta_wa] <= meta_wd;
    end
    if (chars_we) begin
      chars_mem[meta_wa] <= pend_q;
    end
    if (rd_en) begin
      meta_rd_q  <= meta_mem[rd_addr];
      chars_rd_q <= chars_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      idx_q       <= '0;
      cidx_q      <= '0;
      vld_q       <= 1'b0;
      pend_q      <= '0;
      plen_q      <= '0;
      mode_rep_q  <= 1'b0;
      dropped_q   <= 1'b0;
      drop_len_q  <= '0;
      rank_q      <= '0;
      found_q     <= 1'b0;
      more_q      <= 1'b0;
      best_q      <= '0;
      bslot_q     <= '0;
      blen_q      <= '0;
      rslot_q     <= '0;
      rpos_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // Load a new result, or drop the held one once it transfers.
      if (out_set) begin
        out_valid_q <= 1'b1;
        out_q       <= out_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      // Advance the read pointer and track the entry whose data is in flight.
      vld_q  <= rd_issue;
      cidx_q <= idx_q;
      if (rd_issue) begin
        idx_q <= idx_q + (AW+1)'(1);
      end

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (in_data_i.func)
              wftt_pkg::FUNC_TEXT: begin
                if (wftt_pkg::is_space(in_data_i.text_byte)) begin
                  if (plen_q != '0) begin
                    mode_rep_q <= 1'b0;
                    idx_q      <= '0;
                    state_q    <= S_SCAN;
                  end
                end else if (32'(plen_q) < WORD_CHARS) begin
                  // Drop characters past the word limit until the next whitespace.
                  pend_q[PW'(plen_q)] <= wftt_pkg::to_lower(in_data_i.text_byte);
                  plen_q              <= plen_q + LW'(1);
                end
              end
              wftt_pkg::FUNC_REPORT: begin
                mode_rep_q <= 1'b1;
                dropped_q  <= 1'b0;
                rank_q     <= '0;
                idx_q      <= '0;
                found_q    <= 1'b0;
                more_q     <= 1'b0;
                best_q     <= '0;
                state_q    <= (plen_q != '0) ? S_SCAN : S_RANK;
              end
              wftt_pkg::FUNC_READ: begin
                rslot_q <= in_data_i.slot;
                rpos_q  <= in_data_i.char_pos;
                state_q <= S_READ;
              end
              default: begin
              end
            endcase
          end
        end

        S_SCAN: begin
          if ((vld_q && word_match) || scan_done) begin
            logic drop;
            drop = !(vld_q && word_match) && table_full;
            if (!(vld_q && word_match) && !table_full) begin
              used_q <= used_q + (AW+1)'(1);
            end
            plen_q     <= '0;
            drop_len_q <= plen_q;
            idx_q      <= '0;
            if (mode_rep_q) begin
              dropped_q <= drop;
              found_q   <= 1'b0;
              more_q    <= 1'b0;
              best_q    <= '0;
              state_q   <= S_RANK;
            end else begin
              state_q <= drop ? S_DROP : S_IDLE;
            end
          end
        end

        S_RANK: begin
          if (vld_q && !meta_rd_q.taken) begin
            // Strict compare keeps the lowest slot on a tie.
            if (found_q) begin
              more_q <= 1'b1;
            end
            found_q <= 1'b1;
            if (meta_rd_q.cnt > best_q) begin
              best_q  <= meta_rd_q.cnt;
              bslot_q <= cidx_q;
              blen_q  <= meta_rd_q.len;
            end
          end
          if (scan_done && out_free) begin
            if (found_q) begin
              if (more_ranks) begin
                rank_q  <= rank_q + RW'(1);
                idx_q   <= '0;
                found_q <= 1'b0;
                more_q  <= 1'b0;
                best_q  <= '0;
              end else begin
                state_q <= drop_follows ? S_DROP : S_IDLE;
              end
            end else begin
              state_q <= (dropped_q && (TOP_COUNT > 1)) ? S_DROP : S_IDLE;
            end
          end
        end

        S_DROP: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end

        S_READ: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule
